// ===== sv/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define GBTE_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gbte assertion failed");

// next-cycle implication, disabled in reset
`define GBTE_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gbte assertion failed");

`endif

// ===== sv/gbte_pkg.sv =====
// shared constants and types for the gap buffer text engine
package gbte_pkg;

  localparam int BUF_SIZE = 4096;
  localparam int ADDR_W   = $clog2(BUF_SIZE);
  localparam int POS_W    = ADDR_W + 1;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;

  localparam logic [POS_W-1:0] BUF_END = POS_W'(BUF_SIZE);

  typedef enum logic [3:0] {
    CMD_LEFT      = 4'd0,
    CMD_RIGHT     = 4'd1,
    CMD_TOP       = 4'd2,
    CMD_BOTTOM    = 4'd3,
    CMD_LINE_BEG  = 4'd4,
    CMD_LINE_END  = 4'd5,
    CMD_WORD_LEFT = 4'd6,
    CMD_WORD_RGHT = 4'd7,
    CMD_INSERT    = 4'd8,
    CMD_BACKSPACE = 4'd9,
    CMD_DELETE    = 4'd10,
    CMD_PEEK      = 4'd11
  } cmd_t;

  // space, tab, lf, vt, ff, cr
  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_HT && c <= CH_CR);
  endfunction

endpackage

// ===== sv/gap_buffer_text_engine.sv =====
// gap buffer text engine: command sequencer around one byte store
//
//   channel  | signals                         | payload
//   ---------+---------------------------------+-------------------------------
//   in       | in_valid / in_ready             | command, char_in
//   out      | out_valid / out_ready           | cursor, text_length,
//            |                                 | char_at_cursor, at_end,
//            |                                 | buffer_full
//
// one command at a time; in_ready is high only while the sequencer is idle.
// moves without a scan go straight to the final read; line and word scans
// read and evaluate each byte visited, and gap moves read and then write
// each byte moved. rst is synchronous, active high; the store has no reset
// and needs no clearing. a result held by out_ready low stalls only the next
// command's final step.
module gap_buffer_text_engine import gbte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       command,
  input  logic [7:0]       char_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] cursor,
  output logic [POS_W-1:0] text_length,
  output logic [7:0]       char_at_cursor,
  output logic             at_end,
  output logic             buffer_full
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN_RD = 7'b0000010,
    S_SCAN_EV = 7'b0000100,
    S_MOVE_RD = 7'b0001000,
    S_MOVE_WR = 7'b0010000,
    S_FIN_RD  = 7'b0100000,
    S_FIN_EV  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [7:0] mem [BUF_SIZE];
  logic [7:0] rdata;
  logic             rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0]        wr_data;

  logic [POS_W-1:0] gap_start, gap_start_next;
  logic [POS_W-1:0] gap_end, gap_end_next;
  logic [POS_W-1:0] cur_pos, cur_pos_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             phase, phase_next;
  cmd_t             cmd_r;
  logic [7:0]       ch_r;
  logic             mv_left, mv_left_next;
  logic             out_load;

  logic [POS_W-1:0] len;
  logic [POS_W-1:0] gap_w;
  logic             rd_white;

  assign gap_w    = gap_end - gap_start;
  assign len      = BUF_END - gap_w;
  assign rd_white = is_white(rdata);
  assign in_ready = (state == S_IDLE);

  // logical offset to store address
  function automatic logic [ADDR_W-1:0] phys(input logic [POS_W-1:0] o,
                                             input logic [POS_W-1:0] gs,
                                             input logic [POS_W-1:0] gw);
    logic [POS_W-1:0] a;
    a = (o < gs) ? o : o + gw;
    return a[ADDR_W-1:0];
  endfunction

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    gap_start_next = gap_start;
    gap_end_next   = gap_end;
    cur_pos_next   = cur_pos;
    pos_next       = pos;
    phase_next     = phase;
    mv_left_next   = mv_left;
    rd_en          = 1'b0;
    rd_addr        = phys(pos, gap_start, gap_w);
    wr_en          = 1'b0;
    wr_addr        = gap_start[ADDR_W-1:0];
    wr_data        = rdata;
    out_load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          pos_next   = cur_pos;
          phase_next = 1'b0;
          state_next = S_FIN_RD;
          priority case (cmd_t'(command))
            CMD_LEFT:  if (cur_pos != '0) cur_pos_next = cur_pos - 1'b1;
            CMD_RIGHT: if (cur_pos < len) cur_pos_next = cur_pos + 1'b1;
            CMD_TOP:    cur_pos_next = '0;
            CMD_BOTTOM: cur_pos_next = len;
            CMD_LINE_BEG, CMD_LINE_END, CMD_WORD_LEFT, CMD_WORD_RGHT:
              state_next = S_SCAN_RD;
            CMD_INSERT, CMD_BACKSPACE, CMD_DELETE:
              state_next = S_MOVE_RD;
            default: ;
          endcase
        end
      end
      // issue a scan read, step over the end of text, or finish the scan
      S_SCAN_RD: begin
        priority case (cmd_r)
          CMD_LINE_BEG: begin
            if (pos == '0) begin
              cur_pos_next = '0;
              state_next   = S_FIN_RD;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = phys(pos - 1'b1, gap_start, gap_w);
              state_next = S_SCAN_EV;
            end
          end
          CMD_LINE_END: begin
            if (pos >= len) begin
              cur_pos_next = (pos != '0) ? pos - 1'b1 : '0;
              state_next   = S_FIN_RD;
            end else begin
              rd_en      = 1'b1;
              state_next = S_SCAN_EV;
            end
          end
          CMD_WORD_LEFT: begin
            if (pos == '0) begin
              cur_pos_next = pos;
              state_next   = S_FIN_RD;
            end else if (pos >= len) begin
              // end of text counts as white space
              if (!phase) phase_next = 1'b1;
              else pos_next = pos - 1'b1;
            end else begin
              rd_en      = 1'b1;
              state_next = S_SCAN_EV;
            end
          end
          default: begin
            // word right
            if (pos >= len) begin
              cur_pos_next = pos;
              state_next   = S_FIN_RD;
            end else begin
              rd_en      = 1'b1;
              state_next = S_SCAN_EV;
            end
          end
        endcase
      end
      // evaluate the scanned byte
      S_SCAN_EV: begin
        state_next = S_SCAN_RD;
        priority case (cmd_r)
          CMD_LINE_BEG: begin
            if (rdata == CH_LF) begin
              cur_pos_next = pos;
              state_next   = S_FIN_RD;
            end else begin
              pos_next = pos - 1'b1;
            end
          end
          CMD_LINE_END: begin
            if (rdata == CH_LF) begin
              cur_pos_next = pos;
              state_next   = S_FIN_RD;
            end else begin
              pos_next = pos + 1'b1;
            end
          end
          CMD_WORD_LEFT: begin
            if (rd_white == phase) pos_next = pos - 1'b1;
            else if (!phase) phase_next = 1'b1;
            else begin
              cur_pos_next = pos;
              state_next   = S_FIN_RD;
            end
          end
          default: begin
            if (rd_white == phase) pos_next = pos + 1'b1;
            else if (!phase) phase_next = 1'b1;
            else begin
              cur_pos_next = pos;
              state_next   = S_FIN_RD;
            end
          end
        endcase
      end
      // move the gap one byte toward the cursor, or edit at the gap
      S_MOVE_RD: begin
        if (cur_pos < gap_start) begin
          rd_en        = 1'b1;
          rd_addr      = ADDR_W'(gap_start - 1'b1);
          mv_left_next = 1'b1;
          state_next   = S_MOVE_WR;
        end else if (cur_pos > gap_start) begin
          rd_en        = 1'b1;
          rd_addr      = gap_end[ADDR_W-1:0];
          mv_left_next = 1'b0;
          state_next   = S_MOVE_WR;
        end else begin
          state_next = S_FIN_RD;
          priority case (cmd_r)
            CMD_INSERT: begin
              if (gap_start < gap_end) begin
                wr_en          = 1'b1;
                wr_data        = (ch_r == CH_CR) ? CH_LF : ch_r;
                gap_start_next = gap_start + 1'b1;
              end
              cur_pos_next = gap_start_next;
            end
            CMD_BACKSPACE: begin
              if (gap_start != '0) gap_start_next = gap_start - 1'b1;
              cur_pos_next = gap_start_next;
            end
            default: begin
              if (gap_end < BUF_END) gap_end_next = gap_end + 1'b1;
            end
          endcase
        end
      end
      S_MOVE_WR: begin
        wr_en      = 1'b1;
        state_next = S_MOVE_RD;
        if (mv_left) begin
          wr_addr        = ADDR_W'(gap_end - 1'b1);
          gap_start_next = gap_start - 1'b1;
          gap_end_next   = gap_end - 1'b1;
        end else begin
          gap_start_next = gap_start + 1'b1;
          gap_end_next   = gap_end + 1'b1;
        end
      end
      // read the byte under the cursor for the result
      S_FIN_RD: begin
        rd_en      = (cur_pos < len);
        rd_addr    = phys(cur_pos, gap_start, gap_w);
        state_next = S_FIN_EV;
      end
      S_FIN_EV: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_start <= '0;
      gap_end   <= BUF_END;
      cur_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gap_start <= gap_start_next;
      gap_end   <= gap_end_next;
      cur_pos   <= cur_pos_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    phase   <= phase_next;
    mv_left <= mv_left_next;
    if (in_valid && in_ready) begin
      cmd_r <= cmd_t'(command);
      ch_r  <= char_in;
    end
    if (out_load) begin
      cursor         <= cur_pos;
      text_length    <= len;
      char_at_cursor <= (cur_pos < len) ? rdata : 8'h00;
      at_end         <= (cur_pos == len);
      buffer_full    <= (gap_start == gap_end);
    end
  end

endmodule

// ===== sv/gbte_checker.sv =====
// port-level checker for the gap buffer text engine, with its bind
`include "assert_macros.svh"

module gbte_port_checker import gbte_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [3:0]       command,
  input logic [7:0]       char_in,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] cursor,
  input logic [POS_W-1:0] text_length,
  input logic [7:0]       char_at_cursor,
  input logic             at_end,
  input logic             buffer_full
);

  // cursor never passes the end of text
  `GBTE_ASSERT_IMP(a_cur_in_text, clk, rst, out_valid, cursor <= text_length)
  // end flag agrees with the cursor position
  `GBTE_ASSERT_IMP(a_at_end, clk, rst, out_valid, at_end == (cursor == text_length))
  // no byte under the cursor at the end of text
  `GBTE_ASSERT_IMP(a_end_byte, clk, rst, out_valid && at_end, char_at_cursor == 8'h00)
  // full means the text fills the whole store
  `GBTE_ASSERT_IMP(a_full, clk, rst, out_valid, buffer_full == (text_length == BUF_END))
  // a stalled result holds
  `GBTE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(cursor) && $stable(text_length))

endmodule

bind gap_buffer_text_engine gbte_port_checker u_gbte_port_checker (.*);
